/* rtl/wtsp_pkg.sv */
// Package for the world to screen projection: payload types, register codes, widths.
package wtsp_pkg;

    typedef struct packed {
        logic signed [23:0] world_x;
        logic signed [23:0] world_y;
        logic signed [23:0] world_z;
    } wtsp_in_t;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
    } wtsp_out_t;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_ROW_X  = 4'd0;
    localparam cfg_index_t CFG_ROW_Y  = 4'd1;
    localparam cfg_index_t CFG_ROW_W  = 4'd2;
    localparam cfg_index_t CFG_OFF_X  = 4'd3;
    localparam cfg_index_t CFG_OFF_Y  = 4'd4;
    localparam cfg_index_t CFG_OFF_W  = 4'd5;
    localparam cfg_index_t CFG_VIEW_W = 4'd6;
    localparam cfg_index_t CFG_VIEW_H = 4'd7;

    localparam int CLIP_W = 45;   // exact Q.20 clip sum
    localparam int HALF_W = 14;   // floor half of a 15-bit viewport size
    localparam int NUM_W  = CLIP_W + HALF_W;
    localparam int QUOT_W = 18;   // quotient bits kept before saturation
    localparam logic signed [CLIP_W-1:0] W_MIN = 45'sd12288;  // 3/256 in Q.20

    typedef struct packed {
        logic [47:0]        row_x;
        logic [47:0]        row_y;
        logic [47:0]        row_w;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
        logic signed [31:0] off_w;
        logic [14:0]        view_w;
        logic [14:0]        view_h;
    } wtsp_cfg_t;

    typedef struct packed {
        logic              visible;
        logic              neg_x;
        logic              neg_y;
        logic [CLIP_W-1:0] mag_x;
        logic [CLIP_W-1:0] mag_y;
        logic [CLIP_W-1:0] den;
    } wtsp_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } wtsp_q_ctl_t;

endpackage

/* rtl/wtsp_front.sv */
// Front end: accepts points, computes clip x, y, w and classifies visibility.
module wtsp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wtsp_pkg::wtsp_cfg_t  cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wtsp_pkg::wtsp_in_t   s_data,
    input  logic                 q_full,
    output logic                 q_push,
    output wtsp_pkg::wtsp_entry_t q_data
);
    import wtsp_pkg::*;

    logic               v1_reg, v2_reg;
    logic signed [39:0] prod_reg [9];
    logic signed [39:0] prod_next [9];
    logic signed [CLIP_W-1:0] clip_reg [3];
    logic signed [CLIP_W-1:0] clip_next [3];
    logic [47:0]        rows [3];
    logic signed [31:0] offs [3];
    logic signed [23:0] pt [3];
    logic               adv;

    assign rows = '{cfg.row_x, cfg.row_y, cfg.row_w};
    assign offs = '{cfg.off_x, cfg.off_y, cfg.off_w};
    assign pt   = '{s_data.world_x, s_data.world_y, s_data.world_z};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[3*r+k] = $signed(rows[r][16*k +: 16]) * pt[k];
            end
        end
        for (int r = 0; r < 3; r++) begin
            clip_next[r] = CLIP_W'(prod_reg[3*r]) + CLIP_W'(prod_reg[3*r+1])
                         + CLIP_W'(prod_reg[3*r+2])
                         + $signed({offs[r][31], offs[r], 12'd0});
        end
    end

    assign adv     = !v2_reg || !q_full;
    assign s_ready = adv;
    assign q_push  = v2_reg && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            clip_reg <= clip_next;
        end
    end

    always_comb begin
        q_data.visible = clip_reg[2] >= W_MIN;
        q_data.neg_x   = clip_reg[0][CLIP_W-1];
        q_data.neg_y   = clip_reg[1][CLIP_W-1];
        q_data.mag_x   = q_data.neg_x ? CLIP_W'(-clip_reg[0]) : CLIP_W'(clip_reg[0]);
        q_data.mag_y   = q_data.neg_y ? CLIP_W'(-clip_reg[1]) : CLIP_W'(clip_reg[1]);
        q_data.den     = CLIP_W'(clip_reg[2]);
    end

endmodule

/* rtl/wtsp_fifo.sv */
// Short queue between the front end and the divide back end.
module wtsp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  wtsp_pkg::wtsp_entry_t wr_data,
    input  logic                  pop,
    output wtsp_pkg::wtsp_entry_t rd_data,
    output wtsp_pkg::wtsp_q_ctl_t ctl
);
    import wtsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wtsp_entry_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign ctl.push  = push;
    assign ctl.pop   = pop;
    assign ctl.full  = count_reg == CNT_W'(DEPTH);
    assign ctl.empty = count_reg == '0;
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)      count_reg <= CNT_W'(count_reg + 1'b1);
            else if (pop && !push) count_reg <= CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!ctl.full || pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !ctl.empty) else $error("queue underflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

/* rtl/wtsp_back.sv */
// Back end: viewport scaling, pipelined restoring divide by clip w, saturation.
module wtsp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wtsp_pkg::wtsp_cfg_t   cfg,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  wtsp_pkg::wtsp_entry_t q_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wtsp_pkg::wtsp_out_t   m_data
);
    import wtsp_pkg::*;

    localparam int NS = QUOT_W + 1;  // last stage: multiply, range check, divide steps

    typedef struct packed {
        logic              visible;
        logic              neg_x;
        logic              neg_y;
        logic              ovf_x;
        logic              ovf_y;
        logic [NUM_W-1:0]  rem_x;
        logic [NUM_W-1:0]  rem_y;
        logic [QUOT_W-1:0] q_x;
        logic [QUOT_W-1:0] q_y;
        logic [CLIP_W-1:0] den;
    } stage_t;

    localparam int TRIAL_W = CLIP_W + QUOT_W;

    logic [HALF_W-1:0] hw, hh;
    logic              adv;
    logic              v_reg [NS+1];
    stage_t            st_reg [NS+1];
    stage_t            st_next [NS+1];
    wtsp_out_t         out_reg, out_next;
    logic              out_v_reg;

    assign hw    = cfg.view_w[14:1];
    assign hh    = cfg.view_h[14:1];
    assign adv   = !out_v_reg || m_ready;
    assign q_pop = adv && !q_empty;

    always_comb begin
        st_next[0]         = '0;
        st_next[0].visible = q_data.visible;
        st_next[0].neg_x   = q_data.neg_x;
        st_next[0].neg_y   = q_data.neg_y;
        st_next[0].rem_x   = NUM_W'(hw) * NUM_W'(q_data.mag_x);
        st_next[0].rem_y   = NUM_W'(hh) * NUM_W'(q_data.mag_y);
        st_next[0].den     = q_data.den;

        st_next[1]       = st_reg[0];
        st_next[1].ovf_x = TRIAL_W'(st_reg[0].rem_x) >= {st_reg[0].den, QUOT_W'(0)};
        st_next[1].ovf_y = TRIAL_W'(st_reg[0].rem_y) >= {st_reg[0].den, QUOT_W'(0)};

        for (int k = 2; k <= NS; k++) begin
            logic [TRIAL_W-1:0] trial;
            trial      = TRIAL_W'(st_reg[k-1].den) << (QUOT_W - 1 - (k - 2));
            st_next[k] = st_reg[k-1];
            if (TRIAL_W'(st_reg[k-1].rem_x) >= trial) begin
                st_next[k].rem_x = NUM_W'(TRIAL_W'(st_reg[k-1].rem_x) - trial);
                st_next[k].q_x[QUOT_W-1-(k-2)] = 1'b1;
            end
            if (TRIAL_W'(st_reg[k-1].rem_y) >= trial) begin
                st_next[k].rem_y = NUM_W'(TRIAL_W'(st_reg[k-1].rem_y) - trial);
                st_next[k].q_y[QUOT_W-1-(k-2)] = 1'b1;
            end
        end
    end

    function automatic logic signed [15:0] finish(input logic [HALF_W-1:0] base,
                                                  input logic neg, input logic ovf,
                                                  input logic [QUOT_W-1:0] q);
        logic signed [QUOT_W+3:0] mag;
        logic signed [QUOT_W+3:0] sum;
        mag = ovf ? $signed((QUOT_W+4)'(1) << QUOT_W) : $signed((QUOT_W+4)'(q));
        sum = $signed((QUOT_W+4)'(base)) + (neg ? -mag : mag);
        if (sum > $signed((QUOT_W+4)'(32767)))       return 16'sh7fff;
        else if (sum < -$signed((QUOT_W+4)'(32768))) return 16'sh8000;
        else                                         return 16'(sum);
    endfunction

    always_comb begin
        out_next = '0;
        if (st_reg[NS].visible) begin
            out_next.visible  = 1'b1;
            out_next.screen_x = finish(hw, st_reg[NS].neg_x, st_reg[NS].ovf_x,
                                       st_reg[NS].q_x);
            out_next.screen_y = finish(hh, !st_reg[NS].neg_y, st_reg[NS].ovf_y,
                                       st_reg[NS].q_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NS; k++) v_reg[k] <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= !q_empty;
            for (int k = 1; k <= NS; k++) v_reg[k] <= v_reg[k-1];
            out_v_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg  <= st_next;
            out_reg <= out_next;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/world_to_screen_projection.sv */
// Top level of the world to screen projection: register file and front/queue/back wiring.
//
// Projects one world point (s_data: Q16.8 x, y, z) to a screen pixel (m_data: visible
// flag and saturated 16-bit x, y). Both channels are valid/ready; a transaction moves
// on a rising edge with valid and ready high.
// The cfg channel writes register cfg_index (0..7) with cfg_data; higher indexes are
// dropped. cfg_ready is always high; write only while no point is in flight.
// Throughput: one point per cycle, sustained while m_ready stays high.
// Path from input transaction to m_valid with an empty queue: two front stages
// (multiply, sum), the queue entry, then scaling multiply, range check,
// 18 restoring divide steps and the output register.
// The front and back halves stall independently; a 4-entry queue sits between them.
// When m_ready is low the back end holds, the queue fills, and then s_ready drops.
// Reset (aresetn low, synchronous) empties the pipeline and queue and loads the
// register defaults: identity x and y rows, zero w row, w offset 1.0, 1920x1080.
module world_to_screen_projection #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  wtsp_pkg::cfg_index_t   cfg_index,
    input  logic [47:0]            cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  wtsp_pkg::wtsp_in_t     s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output wtsp_pkg::wtsp_out_t    m_data
);
    import wtsp_pkg::*;

    wtsp_cfg_t   cfg_reg;
    wtsp_entry_t q_wr, q_rd;
    wtsp_q_ctl_t q_ctl;
    logic        q_push, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_x  <= 48'd4096;
            cfg_reg.row_y  <= 48'd268435456;
            cfg_reg.row_w  <= 48'd0;
            cfg_reg.off_x  <= 32'sd0;
            cfg_reg.off_y  <= 32'sd0;
            cfg_reg.off_w  <= 32'sd256;
            cfg_reg.view_w <= 15'd1920;
            cfg_reg.view_h <= 15'd1080;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROW_X:  cfg_reg.row_x  <= cfg_data;
                CFG_ROW_Y:  cfg_reg.row_y  <= cfg_data;
                CFG_ROW_W:  cfg_reg.row_w  <= cfg_data;
                CFG_OFF_X:  cfg_reg.off_x  <= $signed(cfg_data[31:0]);
                CFG_OFF_Y:  cfg_reg.off_y  <= $signed(cfg_data[31:0]);
                CFG_OFF_W:  cfg_reg.off_w  <= $signed(cfg_data[31:0]);
                CFG_VIEW_W: cfg_reg.view_w <= cfg_data[14:0];
                CFG_VIEW_H: cfg_reg.view_h <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    wtsp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_ctl.full),
        .q_push  (q_push),
        .q_data  (q_wr)
    );

    wtsp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .ctl     (q_ctl)
    );

    wtsp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_ctl.empty),
        .q_pop   (q_pop),
        .q_data  (q_rd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* test/testbench.sv */
// Testbench for the world to screen projection: directed table plus random points, checked against a predictor.
`timescale 1ns / 1ps

module testbench;
    import wtsp_pkg::*;

    localparam int LATENCY    = 24;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic        chk;
        wtsp_in_t    pt;
        wtsp_out_t   exp_res;
    } pt_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    wtsp_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    wtsp_out_t   m_data;

    wtsp_cfg_t   proj_cfg;
    wtsp_out_t   pixel_q[$];
    int          n_errors = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;

    world_to_screen_projection dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint clip_of(logic [47:0] row, logic signed [31:0] off,
                                       wtsp_in_t pt);
        longint acc;
        acc = longint'($signed(row[15:0])) * longint'(pt.world_x)
            + longint'($signed(row[31:16])) * longint'(pt.world_y)
            + longint'($signed(row[47:32])) * longint'(pt.world_z)
            + longint'(off) * 4096;
        return acc;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic wtsp_out_t project_point(wtsp_in_t pt);
        wtsp_out_t r;
        longint cx, cy, cw, hw, hh;
        cx = clip_of(proj_cfg.row_x, proj_cfg.off_x, pt);
        cy = clip_of(proj_cfg.row_y, proj_cfg.off_y, pt);
        cw = clip_of(proj_cfg.row_w, proj_cfg.off_w, pt);
        r = '0;
        if (cw >= 12288) begin
            hw = proj_cfg.view_w / 2;
            hh = proj_cfg.view_h / 2;
            r.visible  = 1'b1;
            r.screen_x = clamp16(hw + (hw * cx) / cw);
            r.screen_y = clamp16(hh - (hh * cy) / cw);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW_X:  proj_cfg.row_x  = val;
            CFG_ROW_Y:  proj_cfg.row_y  = val;
            CFG_ROW_W:  proj_cfg.row_w  = val;
            CFG_OFF_X:  proj_cfg.off_x  = val[31:0];
            CFG_OFF_Y:  proj_cfg.off_y  = val[31:0];
            CFG_OFF_W:  proj_cfg.off_w  = val[31:0];
            CFG_VIEW_W: proj_cfg.view_w = val[14:0];
            CFG_VIEW_H: proj_cfg.view_h = val[14:0];
            default: ;
        endcase
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_point(wtsp_in_t pt);
        int g;
        g = gap_len();
        if (g != 0) s_valid <= 1'b0;
        repeat (g) @(posedge aclk);
        s_valid <= 1'b1;
        s_data  <= pt;
        pixel_q.push_back(project_point(pt));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [15:0] rnd_coef();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic wtsp_in_t rnd_point();
        wtsp_in_t p;
        p.world_x = 24'($urandom);
        p.world_y = 24'($urandom);
        p.world_z = 24'($urandom);
        if ($urandom_range(0, 1)) begin
            p.world_x = 24'(int'($urandom_range(0, 20000)) - 10000);
            p.world_y = 24'(int'($urandom_range(0, 20000)) - 10000);
            p.world_z = 24'(int'($urandom_range(256, 20000)));
        end
        return p;
    endfunction

    // receiver
    initial begin
        wtsp_out_t want;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pixel_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    want = pixel_q.pop_front();
                    if (m_data.visible !== want.visible)
                        report_mismatch("visible", m_data.visible, want.visible);
                    if (m_data.screen_x !== want.screen_x)
                        report_mismatch("screen_x", m_data.screen_x, want.screen_x);
                    if (m_data.screen_y !== want.screen_y)
                        report_mismatch("screen_y", m_data.screen_y, want.screen_y);
                end
            end
            if (!aresetn || hold_off) m_ready <= 1'b0;
            else if ($urandom_range(0, 9) < 7) m_ready <= 1'b1;
            else if ($urandom_range(0, 19) == 0) m_ready <= 1'b0;
            else m_ready <= ($urandom_range(0, 1) == 1);
        end
    end

    // watchdog
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_valid)
                idle_cycles = 0;
            else if (!hold_off)
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("world_to_screen_projection regression: fail");
                $finish;
            end
        end
    end

    pt_row_t dir_tab[$];

    initial begin
        proj_cfg = '{row_x: 48'd4096, row_y: 48'd268435456, row_w: 48'd0,
                     off_x: 32'sd0, off_y: 32'sd0, off_w: 32'sd256,
                     view_w: 15'd1920, view_h: 15'd1080};
        // default zero w row with w offset 1.0 gives cw = 1.0: identity mapping
        dir_tab.push_back('{1'b1, '{24'sd0, 24'sd0, 24'sd0}, '{1'b1, 16'sd960, 16'sd540}});
        dir_tab.push_back('{1'b1, '{24'sd256, 24'sd256, 24'sd0},
                            '{1'b1, 16'sd1920, 16'sd0}});
        dir_tab.push_back('{1'b1, '{24'h7fffff, 24'h800000, 24'h7fffff},
                            '{1'b1, 16'sd32767, 16'sd32767}});
        dir_tab.push_back('{1'b1, '{24'h800000, 24'h7fffff, 24'h800000},
                            '{1'b1, -16'sd32768, -16'sd32768}});
        dir_tab.push_back('{1'b0, '{24'h555555, 24'haaaaaa, 24'h0f0f0f}, '0});
        dir_tab.push_back('{1'b0, '{24'haaaaaa, 24'h555555, 24'hf0f0f0}, '0});
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].chk && project_point(dir_tab[i].pt) !== dir_tab[i].exp_res)
                report_mismatch("table row", i, 0);
            send_point(dir_tab[i].pt);
        end
        drain();

        // w from z: visibility threshold, zero and negative w
        write_reg(CFG_ROW_W, 48'h1000_0000_0000);
        write_reg(CFG_OFF_W, 48'd0);
        write_reg(4'd9, 48'hffff_ffff_ffff);
        send_point('{24'sd100, 24'sd100, 24'sd3});
        send_point('{24'sd100, 24'sd100, 24'sd2});
        send_point('{24'sd100, 24'sd100, 24'sd0});
        send_point('{24'sd100, 24'sd100, -24'sd1});
        send_point('{24'sd100, -24'sd100, 24'sd256});
        send_point('{24'h7fffff, 24'h800000, 24'sd3});
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_VIEW_W, 48'd0);
                    write_reg(CFG_VIEW_H, 48'd0);
                end
                1: begin
                    write_reg(CFG_VIEW_W, 48'h7fff);
                    write_reg(CFG_VIEW_H, 48'h7fff);
                    write_reg(CFG_OFF_X, 48'h0000_8000_0000);
                    write_reg(CFG_OFF_Y, 48'h0000_7fff_ffff);
                end
                2: begin
                    write_reg(CFG_VIEW_W, 48'd16384);
                    write_reg(CFG_VIEW_H, 48'd1);
                    write_reg(CFG_OFF_W, 48'hffff_8000_0000);
                end
                3: begin
                    write_reg(CFG_ROW_X, 48'h7fff_7fff_7fff);
                    write_reg(CFG_ROW_Y, 48'h8000_8000_8000);
                    write_reg(CFG_OFF_W, 48'h0000_7fff_ffff);
                end
                default: begin
                    write_reg(CFG_ROW_X, {rnd_coef(), rnd_coef(), rnd_coef()});
                    write_reg(CFG_ROW_Y, {rnd_coef(), rnd_coef(), rnd_coef()});
                    write_reg(CFG_ROW_W, {rnd_coef(), rnd_coef(),
                                          16'(int'($urandom_range(1, 8192)))});
                    write_reg(CFG_OFF_X, {16'h0, 32'($urandom)});
                    write_reg(CFG_OFF_Y, {16'h0, 32'($urandom)});
                    write_reg(CFG_OFF_W, {16'h0, 32'(int'($urandom_range(0, 4096)) - 1024)});
                    write_reg(CFG_VIEW_W, 48'($urandom_range(0, 16384)));
                    write_reg(CFG_VIEW_H, 48'($urandom_range(0, 16384)));
                end
            endcase
            if (ph == 5) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 200; k++) send_point(rnd_point());
            drain();
        end

        if (n_errors == 0) begin
            $display("world_to_screen_projection regression: pass");
        end else begin
            $display("world_to_screen_projection regression: fail");
        end
        $finish;
    end
endmodule
